// File: src/dlb_pkg.sv
// Package for the discrete log block: widths, table depth, multiplier request/response types.
// No dependencies.
package dlb_pkg;
  localparam int MOD_BITS = 16;
  localparam int EXP_BITS = 17;
  localparam int TABLE_DEPTH = 257;
  localparam int TAB_AW = $clog2(TABLE_DEPTH);
  localparam int OFF_BITS = 5;
  localparam int CNT_BITS = $clog2(MOD_BITS + 2);

  // modular multiply request/response between top and the serial unit
  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] x;
    logic [MOD_BITS-1:0] y;
    logic [MOD_BITS-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] p;
  } mm_rsp_t;
endpackage

// File: src/dlb_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on dlb_pkg. Operands must be below the modulus.
module dlb_modmul (
  input  logic            clk,
  input  logic            rst_n,
  input  dlb_pkg::mm_req_t req,
  output dlb_pkg::mm_rsp_t rsp
);
  logic [dlb_pkg::MOD_BITS-1:0] acc_r, acc_nxt, x_r, y_r, y_nxt, m_r;
  logic [dlb_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [dlb_pkg::MOD_BITS:0] dbl, dbl_red, add, add_red;

  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add = dbl_red + (y_r[dlb_pkg::MOD_BITS-1] ? {1'b0, x_r} : '0);
    add_red = (add >= {1'b0, m_r}) ? add - {1'b0, m_r} : add;
    acc_nxt = acc_r;
    y_nxt = y_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      y_nxt = req.y;
      cnt_nxt = dlb_pkg::CNT_BITS'(dlb_pkg::MOD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = add_red[dlb_pkg::MOD_BITS-1:0];
      y_nxt = {y_r[dlb_pkg::MOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dlb_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    y_r <= y_nxt;
    if (req.start) begin
      x_r <= req.x;
      m_r <= req.m;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p = acc_r;
endmodule

// File: src/dlb_divmod.sv
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on dlb_pkg. Divisor must be nonzero.
module dlb_divmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dlb_pkg::MOD_BITS-1:0] num,
  input  logic [dlb_pkg::MOD_BITS-1:0] den,
  output logic                         done,
  output logic [dlb_pkg::MOD_BITS-1:0] quo,
  output logic [dlb_pkg::MOD_BITS-1:0] rem
);
  logic [dlb_pkg::MOD_BITS-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [dlb_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [dlb_pkg::MOD_BITS:0] sh;

  always_comb begin
    sh = {r_r, q_r[dlb_pkg::MOD_BITS-1]};
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = num;
      r_nxt = '0;
      cnt_nxt = dlb_pkg::CNT_BITS'(dlb_pkg::MOD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = dlb_pkg::MOD_BITS'(sh - {1'b0, d_r});
        q_nxt = {q_r[dlb_pkg::MOD_BITS-2:0], 1'b1};
      end else begin
        r_nxt = sh[dlb_pkg::MOD_BITS-1:0];
        q_nxt = {q_r[dlb_pkg::MOD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dlb_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= den;
  end

  assign done = done_r;
  assign quo = q_r;
  assign rem = r_r;
endmodule

// File: src/discrete_log_bsgs.sv
// Discrete log by baby-step giant-step, one item at a time.
// Multiplies and divides run on the serial units. With n = ceil(sqrt(m)): n+1 baby steps
// and n steps for a^n, then per giant step one multiply and a scan of the table
// (n+1 entries). Each gcd reduction round runs the Euclid steps, one divide each.
// Next item is taken once the result has been accepted. Reset (rst_n synchronous, low)
// clears the sequencer and the result valid; the key table is not cleared.
module discrete_log_bsgs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_base,
  input  logic [15:0] in_target,
  input  logic [15:0] in_modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_exponent,
  output logic        out_found
);
  localparam int W = dlb_pkg::MOD_BITS;
  localparam int AW = dlb_pkg::TAB_AW;
  localparam int EW = dlb_pkg::EXP_BITS;

  localparam logic [4:0] S_IDLE = 5'd0, S_RA = 5'd1, S_RB = 5'd2, S_CHK = 5'd3,
    S_GCD = 5'd4, S_GCDW = 5'd5, S_GTST = 5'd6, S_DB = 5'd7, S_DBW = 5'd8,
    S_DM = 5'd9, S_DMW = 5'd10, S_DA = 5'd11, S_DAW = 5'd12, S_MC = 5'd13,
    S_MCW = 5'd14, S_SQ = 5'd15, S_BABY = 5'd16, S_BABYW = 5'd17,
    S_AN = 5'd18, S_ANW = 5'd19, S_GI = 5'd20, S_GIW = 5'd21,
    S_SRCH = 5'd22, S_SRCHW = 5'd23, S_CM = 5'd24, S_CMW = 5'd25, S_RM = 5'd26;

  logic [4:0] st_r, st_nxt;
  logic [W-1:0] a_r, b_r, m_r, coef_r, cur_r, an_r, g_x_r, g_y_r;
  logic [W-1:0] tmp_r;
  logic [W:0] n_r, sq_r, q_r, cnt_r, k_r, p_r, pn_r;
  logic [dlb_pkg::OFF_BITS-1:0] off_r;
  logic [EW-1:0] res_e_r;
  logic res_f_r, ov_r;
  logic fin, fin_f;
  logic [EW-1:0] fin_e;

  logic [W-1:0] keys [dlb_pkg::TABLE_DEPTH];
  logic [W-1:0] rd_r;
  logic [AW-1:0] rd_a;

  dlb_pkg::mm_req_t mreq;
  dlb_pkg::mm_rsp_t mrsp;
  logic dv_start, dv_done;
  logic [W-1:0] dv_num, dv_den, dv_q, dv_r;

  dlb_modmul u_mm (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  dlb_divmod u_dv (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_q), .rem(dv_r));

  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_exponent = res_e_r;
  assign out_found = res_f_r;
  assign rd_a = AW'(k_r - 1'b1);

  always_ff @(posedge clk) begin
    if (st_r == S_SRCH && k_r != '0) rd_r <= keys[rd_a];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_BABY && q_r < (W+1)'(dlb_pkg::TABLE_DEPTH))
      keys[AW'(q_r)] <= cur_r;
  end

  always_comb begin
    st_nxt = st_r;
    mreq = '0;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = W'(1);
    fin = 1'b0;
    fin_e = '0;
    fin_f = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid && in_ready) st_nxt = S_RA;
      S_RA: begin
        dv_start = 1'b1; dv_num = a_r; dv_den = m_r; st_nxt = S_RB;
      end
      S_RB: if (dv_done) begin
        dv_start = 1'b1; dv_num = b_r; dv_den = m_r; st_nxt = S_RM;
      end
      S_RM: if (dv_done) st_nxt = S_CHK;
      S_CHK: begin
        if (m_r == W'(1) || b_r == W'(1)) begin
          fin = 1'b1; fin_f = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_GCD;
      end
      S_GCD: begin
        if (g_y_r == '0) st_nxt = S_GTST;
        else begin
          dv_start = 1'b1; dv_num = g_x_r; dv_den = g_y_r; st_nxt = S_GCDW;
        end
      end
      S_GCDW: if (dv_done) st_nxt = S_GCD;
      // g_x_r holds the gcd from here through the divisions below
      S_GTST: begin
        if (g_x_r == W'(1)) st_nxt = S_SQ;
        else if (b_r == coef_r) begin
          fin = 1'b1; fin_e = EW'(off_r); fin_f = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_DB;
      end
      S_DB: begin dv_start = 1'b1; dv_num = b_r; dv_den = g_x_r; st_nxt = S_DBW; end
      S_DBW: if (dv_done) begin
        if (dv_r != '0) begin
          fin = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_DM;
      end
      S_DM: begin dv_start = 1'b1; dv_num = m_r; dv_den = g_x_r; st_nxt = S_DMW; end
      S_DMW: if (dv_done) st_nxt = S_DA;
      S_DA: begin dv_start = 1'b1; dv_num = a_r; dv_den = g_x_r; st_nxt = S_DAW; end
      S_DAW: if (dv_done) st_nxt = S_MC;
      S_MC: begin
        dv_start = 1'b1; dv_num = coef_r; dv_den = m_r; st_nxt = S_MCW;
      end
      S_MCW: if (dv_done) st_nxt = S_CM;
      S_CM: begin
        mreq.start = 1'b1; mreq.x = coef_r; mreq.y = tmp_r; mreq.m = m_r;
        st_nxt = S_CMW;
      end
      S_CMW: if (mrsp.done) st_nxt = S_GCD;
      S_SQ: if (sq_r >= {1'b0, m_r}) st_nxt = S_BABY;
      S_BABY: begin
        mreq.start = 1'b1; mreq.x = cur_r; mreq.y = a_r; mreq.m = m_r;
        st_nxt = S_BABYW;
      end
      S_BABYW: if (mrsp.done) st_nxt = (q_r == n_r) ? S_AN : S_BABY;
      S_AN: begin
        mreq.start = 1'b1; mreq.x = an_r; mreq.y = a_r; mreq.m = m_r;
        st_nxt = S_ANW;
      end
      S_ANW: if (mrsp.done) st_nxt = (q_r + 1'b1 == n_r) ? S_GI : S_AN;
      S_GI: begin
        mreq.start = 1'b1; mreq.x = cur_r; mreq.y = an_r; mreq.m = m_r;
        st_nxt = S_GIW;
      end
      S_GIW: if (mrsp.done) st_nxt = S_SRCH;
      S_SRCH: begin
        if (k_r != '0) st_nxt = S_SRCHW;
        else if (p_r == n_r + 1'b1) begin
          fin = 1'b1; st_nxt = S_IDLE;
        end else st_nxt = S_GI;
      end
      // scan from the highest baby index down so the larger index wins
      S_SRCHW: begin
        if (rd_r == cur_r) begin
          fin = 1'b1; fin_f = 1'b1; st_nxt = S_IDLE;
          fin_e = pn_r - (k_r - 1'b1) + EW'(off_r);
        end else st_nxt = S_SRCH;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (fin) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (fin) begin
        res_e_r <= fin_e;
        res_f_r <= fin_f;
      end
      unique case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          a_r <= in_base; b_r <= in_target;
          m_r <= (in_modulus == '0) ? W'(1) : in_modulus;
          coef_r <= W'(1); off_r <= '0;
        end
        S_RB: if (dv_done) a_r <= dv_r;
        S_RM: if (dv_done) b_r <= dv_r;
        S_CHK: begin g_x_r <= a_r; g_y_r <= m_r; end
        S_GCDW: if (dv_done) begin g_x_r <= g_y_r; g_y_r <= dv_r; end
        S_GTST: begin n_r <= (W+1)'(1); sq_r <= (W+1)'(1); end
        S_DBW: if (dv_done) b_r <= dv_q;
        S_DMW: if (dv_done) m_r <= dv_q;
        S_DAW: if (dv_done) tmp_r <= dv_q;
        S_MCW: if (dv_done) coef_r <= dv_r;
        S_CMW: if (mrsp.done) begin
          coef_r <= mrsp.p; off_r <= off_r + 1'b1;
          g_x_r <= a_r; g_y_r <= m_r;
        end
        // advance n while n*n < m, keeping n*n by adding 2n+1
        S_SQ: begin
          if (sq_r < {1'b0, m_r}) begin
            n_r <= n_r + 1'b1;
            sq_r <= sq_r + {n_r[W-1:0], 1'b1};
          end else begin
            q_r <= '0; cur_r <= b_r; cnt_r <= '0;
          end
        end
        S_BABY: begin
          if (q_r < (W+1)'(dlb_pkg::TABLE_DEPTH)) cnt_r <= q_r + 1'b1;
        end
        S_BABYW: if (mrsp.done) begin
          cur_r <= mrsp.p;
          if (q_r == n_r) begin
            q_r <= '0; an_r <= W'(1);
          end else q_r <= q_r + 1'b1;
        end
        S_ANW: if (mrsp.done) begin
          an_r <= mrsp.p;
          if (q_r + 1'b1 == n_r) begin
            p_r <= (W+1)'(1); pn_r <= n_r; cur_r <= coef_r;
          end else q_r <= q_r + 1'b1;
        end
        S_GIW: if (mrsp.done) begin cur_r <= mrsp.p; k_r <= cnt_r; end
        S_SRCH: if (k_r == '0 && p_r != n_r + 1'b1) begin
          p_r <= p_r + 1'b1; pn_r <= pn_r + n_r;
        end
        S_SRCHW: if (rd_r != cur_r) k_r <= k_r - 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// File: src/dlb_checker.sv
// Port-level checker for discrete_log_bsgs, attached by bind.
// Depends only on the top-level ports.
module dlb_checker (
  input logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, out_found,
  input logic [16:0] out_exponent
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_exponent)) else $error("hold");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("overlap");
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_exponent == '0) else $error("nf");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy");
endmodule

bind discrete_log_bsgs dlb_checker u_chk (.clk, .rst_n, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_found, .out_exponent);

// File: dv/tb_discrete_log_bsgs.sv
// Testbench for discrete_log_bsgs: directed and random items checked against a
// built-in baby-step giant-step predictor. Depends on dlb_pkg and the block.
module tb_discrete_log_bsgs;
  localparam int MOD_BITS = dlb_pkg::MOD_BITS;
  localparam int EXP_BITS = dlb_pkg::EXP_BITS;
  localparam int TABLE_DEPTH = dlb_pkg::TABLE_DEPTH;

  localparam int CYCLE_LIMIT = 30000000;

  typedef struct {
    logic [EXP_BITS-1:0] exponent;
    logic                found;
  } dlog_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MOD_BITS-1:0] in_base = '0;
  logic [MOD_BITS-1:0] in_target = '0;
  logic [MOD_BITS-1:0] in_modulus = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [EXP_BITS-1:0] out_exponent;
  logic                out_found;

  dlog_res_t pending_logs[$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  bit        no_stall = 1'b0;

  discrete_log_bsgs u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned a, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    a = a % m;
    while (e != 0) begin
      if (e[0]) r = (r * a) % m;
      a = (a * a) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  // Least x with a^x = b mod m, with gcd reduction then baby/giant steps.
  function automatic dlog_res_t solve_dlog(logic [MOD_BITS-1:0] base_i,
                                           logic [MOD_BITS-1:0] targ_i,
                                           logic [MOD_BITS-1:0] mod_i);
    longint unsigned keys[TABLE_DEPTH];
    longint unsigned m, a, b, coef, off, n, cur, an, g, x, y, t, cnt;
    dlog_res_t res;
    m = (mod_i == '0) ? 64'd1 : 64'(mod_i);
    a = 64'(base_i) % m;
    b = 64'(targ_i) % m;
    coef = 1;
    off = 0;
    res.exponent = '0;
    res.found = 1'b1;
    if (m == 1 || b == 1) return res;
    forever begin
      x = a; y = m;
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      g = x;
      if (g == 1) break;
      if (b == coef) begin
        res.exponent = off[EXP_BITS-1:0];
        return res;
      end
      if (b % g != 0) begin
        res.found = 1'b0;
        return res;
      end
      b = b / g;
      m = m / g;
      coef = (coef * (a / g)) % m;
      off++;
    end
    n = 1;
    while (n * n < m) n++;
    cnt = 0;
    cur = b;
    for (longint unsigned q = 0; q <= n; q++) begin
      if (q < TABLE_DEPTH) begin
        keys[q] = cur;
        cnt = q + 1;
      end
      cur = (cur * a) % m;
    end
    an = pow_mod(a, n, m);
    cur = coef;
    for (longint unsigned p = 1; p <= n + 1; p++) begin
      cur = (cur * an) % m;
      // larger baby index wins on a repeated key
      for (longint unsigned k = cnt; k > 0; k--) begin
        if (keys[k-1] == cur) begin
          x = p * n - (k - 1) + off;
          res.exponent = x[EXP_BITS-1:0];
          return res;
        end
      end
    end
    res.found = 1'b0;
    return res;
  endfunction

  task automatic send_item(logic [MOD_BITS-1:0] b, logic [MOD_BITS-1:0] t,
                           logic [MOD_BITS-1:0] m);
    int gap;
    gap = no_stall ? 0 : short_or_long_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_base    <= b;
    in_target  <= t;
    in_modulus <= m;
    do @(posedge clk); while (!in_ready);
    pending_logs.push_back(solve_dlog(b, t, m));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_logs.size() != 0);
  endtask

  task automatic test_directed();
    send_item(16'd3, 16'd13, 16'd17);
    send_item(16'd5, 16'd1, 16'd7);          // target one
    send_item(16'd0, 16'd0, 16'd1);          // unit modulus
    send_item(16'd9, 16'd4, 16'd0);          // zero modulus
    send_item(16'd0, 16'd0, 16'd10);         // zero base, zero target
    send_item(16'd0, 16'd5, 16'd10);         // zero base, no solution
    send_item(16'd2, 16'd0, 16'd16);         // gcd path, reduces to unit modulus
    send_item(16'd2, 16'd8, 16'd24);
    send_item(16'd6, 16'd3, 16'd12);         // gcd path, not divisible
    send_item(16'd4, 16'd2, 16'd7);          // base of order three, target in its subgroup
    send_item(16'd3, 16'd10, 16'd10);        // target reduces to zero
    send_item(16'd20, 16'd34, 16'd17);       // operands above modulus
    send_item(16'hFFFF, 16'hFFFE, 16'hFFFF); // extremes
    send_item(16'd3, 16'd2, 16'd65521);      // largest prime modulus
    send_item(16'd2, 16'h4000, 16'h8000);
    send_item(16'd0, 16'd0, 16'hFFFF);
  endtask

  task automatic test_random(int n_items);
    logic [MOD_BITS-1:0] b, t, m;
    for (int i = 0; i < n_items; i++) begin
      no_stall = (i >= 40 && i < 55);
      m = ($urandom_range(0, 30) == 0) ? MOD_BITS'($urandom_range(16384, 65535))
                                       : MOD_BITS'($urandom_range(1, 1023));
      b = MOD_BITS'($urandom_range(0, 65535));
      // mostly solvable targets, the rest noise
      if ($urandom_range(0, 2) != 0)
        t = MOD_BITS'(pow_mod(64'(b), 64'($urandom_range(0, 2 * m)), 64'(m))
                      + 64'(m) * 64'($urandom_range(0, 65535 / m - 1)));
      else
        t = MOD_BITS'($urandom_range(0, 65535));
      send_item(b, t, m);
    end
    no_stall = 1'b0;
  endtask

  task automatic test_pause_until_idle();
    drain_results();
    send_item(16'd7, 16'd11, 16'd101);
    send_item(16'd12, 16'd36, 16'd60);
  endtask

  always @(posedge clk) begin
    out_ready <= no_stall ? 1'b1 : ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_logs.size() == 0) begin
        $error("result with no item outstanding");
        n_errors++;
      end else begin
        dlog_res_t exp_r;
        exp_r = pending_logs.pop_front();
        if (out_exponent !== exp_r.exponent) begin
          $error("exponent: expected %0d, got %0d", exp_r.exponent, out_exponent);
          n_errors++;
        end
        if (out_found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_found);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL discrete_log_bsgs");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_until_idle();
    test_random(84);
    drain_results();
    repeat (100) @(posedge clk);
    if (n_errors == 0 && pending_logs.size() == 0)
      $display("PASS discrete_log_bsgs");
    else
      $display("FAIL discrete_log_bsgs");
    $finish;
  end
endmodule
